[hdl/infix_expression_syntax_checker_top_macros.svh]
// assertion macros for the infix expression syntax checker
`ifndef INFIX_EXPRESSION_SYNTAX_CHECKER_TOP_MACROS_SVH
`define INFIX_EXPRESSION_SYNTAX_CHECKER_TOP_MACROS_SVH

// clocked assertion, disabled while reset is high
`define IESC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, also checked during reset
`define IESC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/iesc_pkg.sv]
// shared constants and character classes for the infix expression syntax checker
`default_nettype none

package iesc_pkg;

   // deepest parenthesis nesting that is accepted
   localparam int unsigned MAX_DEPTH = 255;
   localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [7:0]         char_type;

   // character codes
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_MINUS  = 8'h2D;
   localparam char_type CH_STAR   = 8'h2A;
   localparam char_type CH_SLASH  = 8'h2F;
   localparam char_type CH_CARET  = 8'h5E;
   localparam char_type CH_LPAREN = 8'h28;
   localparam char_type CH_RPAREN = 8'h29;
   localparam char_type CH_SPACE  = 8'h20;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_NINE   = 8'h39;

   // any arithmetic operator
   function automatic logic is_op(input char_type c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_CARET);
   endfunction

   // operators that cannot follow an open parenthesis
   function automatic logic is_high_op(input char_type c);
      return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_CARET);
   endfunction

   // decimal digit
   function automatic logic is_digit(input char_type c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

endpackage

`default_nettype wire

[hdl/infix_expression_syntax_checker_top.sv]
// top level of the infix expression syntax checker
//
// The expression arrives one ASCII character per req transaction, with
// req_last marking its final character. After the final character one rsp
// transaction carries rsp_valid_res: 1 when the whole expression is well
// formed, 0 when any rule failed. Characters without req_last give no rsp.
// One character is taken every cycle while req_ready is high. Each character
// is held in an input register, checked against the registered history and
// parenthesis depth in the following cycle; when the final character leaves
// that stage the verdict lands in the result register, which drives rsp_valid.
// The rate is set by the history update, one character per cycle while the
// stage does not hold. After the final character all history returns to its
// start value so the next expression can follow at once.
// Synchronous reset returns history and depth to their start values and clears the valid bits of both registers.
// While a verdict waits on rsp_ready, characters keep flowing until a second
// final character reaches the check stage; that stage then holds, and
// req_ready drops until the waiting verdict is taken.
`default_nettype none

`include "infix_expression_syntax_checker_top_macros.svh"

module infix_expression_syntax_checker_top
   import iesc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_valid_res
);

   // input register
   logic      stg_valid_ff, stg_valid_in;
   char_type  stg_ch_ff;
   logic      stg_last_ff;

   // history and depth
   logic      prev_digit_ff,  prev_digit_in;
   logic      prev_space_ff,  prev_space_in;
   logic      prev2_digit_ff, prev2_digit_in;
   logic      pn_op_ff,       pn_op_in;
   logic      pn_lp_ff,       pn_lp_in;
   logic      pn_rp_ff,       pn_rp_in;
   logic      pn_digit_ff,    pn_digit_in;
   logic      first_pending_ff, first_pending_in;
   logic      failed_ff,      failed_in;
   depth_type depth_ff,       depth_in;

   // result register
   logic      rsp_valid_ff,     rsp_valid_in;
   logic      rsp_valid_res_ff, rsp_valid_res_in;

   logic      stg_advance;
   logic      c_op, c_hi, c_digit, c_lp, c_rp, c_sp;
   logic      pair_fail, depth_fail, fail_now;
   depth_type depth_next;

   // character classes of the staged transaction
   assign c_op    = is_op(stg_ch_ff);
   assign c_hi    = is_high_op(stg_ch_ff);
   assign c_digit = is_digit(stg_ch_ff);
   assign c_lp    = (stg_ch_ff == CH_LPAREN);
   assign c_rp    = (stg_ch_ff == CH_RPAREN);
   assign c_sp    = (stg_ch_ff == CH_SPACE);

   // stage holds only when it would produce a second waiting verdict
   assign stg_advance = stg_valid_ff && !(stg_last_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready   = !stg_valid_ff || stg_advance;

   // adjacency rules on the space-free view
   assign pair_fail = !c_sp && ((pn_op_ff && c_op) || (pn_lp_ff && c_hi) ||
                                (pn_op_ff && c_rp) || (pn_digit_ff && c_lp) ||
                                (pn_rp_ff && c_digit));

   // parenthesis depth update with overflow and underflow checks
   always_comb begin
      depth_next = depth_ff;
      depth_fail = 1'b0;
      if (c_lp) begin
         if (depth_ff == DEPTH_W'(MAX_DEPTH)) depth_fail = 1'b1;
         else depth_next = depth_ff + DEPTH_W'(1);
      end else if (c_rp) begin
         if (depth_ff == '0) depth_fail = 1'b1;
         else depth_next = depth_ff - DEPTH_W'(1);
      end
   end

   assign fail_now = failed_ff || (first_pending_ff && c_op) || (stg_last_ff && c_op) ||
                     (prev2_digit_ff && prev_space_ff && c_digit) ||
                     pair_fail || depth_fail ||
                     (stg_last_ff && (depth_next != '0));

   // next state of stage, history and result
   always_comb begin
      stg_valid_in     = stg_valid_ff;
      prev_digit_in    = prev_digit_ff;
      prev_space_in    = prev_space_ff;
      prev2_digit_in   = prev2_digit_ff;
      pn_op_in         = pn_op_ff;
      pn_lp_in         = pn_lp_ff;
      pn_rp_in         = pn_rp_ff;
      pn_digit_in      = pn_digit_ff;
      first_pending_in = first_pending_ff;
      failed_in        = failed_ff;
      depth_in         = depth_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_valid_res_in = rsp_valid_res_ff;

      if (req_ready) stg_valid_in = req_valid;

      if (stg_advance) begin
         if (stg_last_ff) begin
            prev_digit_in    = 1'b0;
            prev_space_in    = 1'b0;
            prev2_digit_in   = 1'b0;
            pn_op_in         = 1'b0;
            pn_lp_in         = 1'b0;
            pn_rp_in         = 1'b0;
            pn_digit_in      = 1'b0;
            first_pending_in = 1'b1;
            failed_in        = 1'b0;
            depth_in         = '0;
            rsp_valid_in     = 1'b1;
            rsp_valid_res_in = !fail_now;
         end else begin
            prev2_digit_in   = prev_digit_ff;
            prev_digit_in    = c_digit;
            prev_space_in    = c_sp;
            first_pending_in = 1'b0;
            failed_in        = fail_now;
            depth_in         = depth_next;
            if (!c_sp) begin
               pn_op_in    = c_op;
               pn_lp_in    = c_lp;
               pn_rp_in    = c_rp;
               pn_digit_in = c_digit;
            end
         end
      end
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff     <= 1'b0;
         prev_digit_ff    <= 1'b0;
         prev_space_ff    <= 1'b0;
         prev2_digit_ff   <= 1'b0;
         pn_op_ff         <= 1'b0;
         pn_lp_ff         <= 1'b0;
         pn_rp_ff         <= 1'b0;
         pn_digit_ff      <= 1'b0;
         first_pending_ff <= 1'b1;
         failed_ff        <= 1'b0;
         depth_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         stg_valid_ff     <= stg_valid_in;
         prev_digit_ff    <= prev_digit_in;
         prev_space_ff    <= prev_space_in;
         prev2_digit_ff   <= prev2_digit_in;
         pn_op_ff         <= pn_op_in;
         pn_lp_ff         <= pn_lp_in;
         pn_rp_ff         <= pn_rp_in;
         pn_digit_ff      <= pn_digit_in;
         first_pending_ff <= first_pending_in;
         failed_ff        <= failed_in;
         depth_ff         <= depth_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_ch_ff   <= req_ch;
         stg_last_ff <= req_last;
      end
      rsp_valid_res_ff <= rsp_valid_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

   // checks
   `IESC_ASSERT(a_last_gives_rsp, stg_advance && stg_last_ff |=> rsp_valid_ff, "final character gave no verdict")
   `IESC_ASSERT(a_last_clears_state, stg_advance && stg_last_ff |=> first_pending_ff && (depth_ff == '0) && !failed_ff, "history not cleared after final character")
   `IESC_ASSERT(a_stall_only_on_rsp, !req_ready |-> rsp_valid_ff && !rsp_ready && stg_last_ff, "input stalled without a waiting verdict")
   `IESC_ASSERT(a_depth_bound, depth_ff <= DEPTH_W'(MAX_DEPTH), "parenthesis depth beyond limit")

endmodule

`default_nettype wire

[bench/syntax_verdict_checker.sv]
// scoreboard that predicts and checks the verdict of each expression
`timescale 1ns / 100ps

module syntax_verdict_checker
   import iesc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  char_type req_ch,
   input  logic     req_last,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  logic     rsp_valid_res,
   output int       error_count,
   output int       verdicts_owed
);

   // role of a character in the syntax rules
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_DIGIT,
      CLS_LOW_OP,
      CLS_HIGH_OP,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_SPACE
   } char_class_type;

   // history of the expression in progress
   char_type  last_raw;
   char_type  older_raw;
   char_type  last_solid;
   bit        have_solid;
   bit        at_start;
   bit        broken;
   depth_type nest_level;

   bit expected_verdicts[$];
   int fail_tally = 0;

   function automatic char_class_type classify(input char_type c);
      case (c)
         CH_PLUS, CH_MINUS:           return CLS_LOW_OP;
         CH_STAR, CH_SLASH, CH_CARET: return CLS_HIGH_OP;
         CH_LPAREN:                   return CLS_OPEN;
         CH_RPAREN:                   return CLS_CLOSE;
         CH_SPACE:                    return CLS_SPACE;
         default:
            return (c inside {[CH_ZERO:CH_NINE]}) ? CLS_DIGIT : CLS_OTHER;
      endcase
   endfunction

   function automatic bit is_operator(input char_class_type k);
      return (k == CLS_LOW_OP) || (k == CLS_HIGH_OP);
   endfunction

   function void clear_history();
      last_raw   = '0;
      older_raw  = '0;
      last_solid = '0;
      have_solid = 1'b0;
      at_start   = 1'b1;
      broken     = 1'b0;
      nest_level = '0;
   endfunction

   // fold one character into the history, queue a verdict on the final one
   task automatic absorb_char(input char_type c, input logic fin);
      char_class_type cur;
      char_class_type prior;
      cur = classify(c);
      if (is_operator(cur) && (at_start || fin))
         broken = 1'b1;
      // digit, single space, digit on the raw text
      if (classify(older_raw) == CLS_DIGIT && last_raw == CH_SPACE && cur == CLS_DIGIT)
         broken = 1'b1;
      if (cur != CLS_SPACE) begin
         if (have_solid) begin
            prior = classify(last_solid);
            if (is_operator(prior) && is_operator(cur)) broken = 1'b1;
            if (prior == CLS_OPEN && cur == CLS_HIGH_OP) broken = 1'b1;
            if (is_operator(prior) && cur == CLS_CLOSE) broken = 1'b1;
            if (prior == CLS_DIGIT && cur == CLS_OPEN) broken = 1'b1;
            if (prior == CLS_CLOSE && cur == CLS_DIGIT) broken = 1'b1;
         end
         // nesting saturates at both ends and marks the expression bad
         if (cur == CLS_OPEN) begin
            if (nest_level >= MAX_DEPTH) broken = 1'b1;
            else nest_level = nest_level + 1'b1;
         end else if (cur == CLS_CLOSE) begin
            if (nest_level == 0) broken = 1'b1;
            else nest_level = nest_level - 1'b1;
         end
         last_solid = c;
         have_solid = 1'b1;
      end
      older_raw = last_raw;
      last_raw  = c;
      at_start  = 1'b0;
      if (fin) begin
         if (nest_level != 0) broken = 1'b1;
         expected_verdicts.push_back(!broken);
         clear_history();
      end
   endtask

   // compare rsp transactions first so a new expectation cannot match early
   always @(posedge clock) begin
      if (reset) begin
         clear_history();
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("%0t: rsp transaction with no verdict pending, got %b",
                           $realtime, rsp_valid_res);
            end else begin
               if (rsp_valid_res !== expected_verdicts[0]) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display("%0t: rsp_valid_res mismatch, expected %b got %b",
                              $realtime, expected_verdicts[0], rsp_valid_res);
               end
               void'(expected_verdicts.pop_front());
            end
         end
         if (req_valid && req_ready)
            absorb_char(req_ch, req_last);
      end
      error_count   <= fail_tally;
      verdicts_owed <= expected_verdicts.size();
   end

endmodule

[bench/tb.sv]
// testbench top for the infix expression syntax checker
`timescale 1ns / 100ps

module tb;
   import iesc_pkg::*;

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   logic     req_ready;
   char_type req_ch        = '0;
   logic     req_last      = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready     = 1'b0;
   logic     rsp_valid_res;

   int error_count;
   int verdicts_owed;

   // no stalls on either side while set
   bit calm = 1'b0;

   char_type expr_text[$];

   localparam int STALL_LIMIT = 2000;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   infix_expression_syntax_checker_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res)
   );

   syntax_verdict_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .error_count   (error_count),
      .verdicts_owed (verdicts_owed)
   );

   // random backpressure on the rsp side
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 34);
   end

   function automatic char_type pick_op();
      case ($urandom_range(4))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         default: return CH_CARET;
      endcase
   endfunction

   // characters that matter to the syntax rules
   function automatic char_type pick_marked();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return pick_op();
         5:             return CH_LPAREN;
         6:             return CH_RPAREN;
         7:             return CH_SPACE;
         default:       return char_type'(CH_ZERO + $urandom_range(9));
      endcase
   endfunction

   task automatic maybe_space();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) expr_text.push_back(CH_SPACE);
   endtask

   // well-formed expression with random numbers, operators and nesting
   task automatic grow_expr(input int nest);
      int terms;
      terms = $urandom_range(1, 3);
      for (int t = 0; t < terms; t++) begin
         if (t > 0) begin
            maybe_space();
            expr_text.push_back(pick_op());
            maybe_space();
         end
         if (nest > 0 && $urandom_range(2) == 0) begin
            expr_text.push_back(CH_LPAREN);
            maybe_space();
            if ($urandom_range(3) == 0) expr_text.push_back(CH_MINUS);
            grow_expr(nest - 1);
            maybe_space();
            expr_text.push_back(CH_RPAREN);
         end else begin
            repeat ($urandom_range(1, 3))
               expr_text.push_back(char_type'(CH_ZERO + $urandom_range(9)));
         end
      end
   endtask

   // one req transaction, with random idle cycles in front of it
   task automatic offer_char(input char_type c, input logic fin);
      bit placed;
      placed = 1'b0;
      while (!placed) begin
         @(negedge clock);
         if (!calm && $urandom_range(99) < 34) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_ch    <= c;
            req_last  <= fin;
            placed = 1'b1;
         end
      end
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_expr();
      for (int i = 0; i < expr_text.size(); i++)
         offer_char(expr_text[i], i == expr_text.size() - 1);
      expr_text.delete();
   endtask

   // stimulus
   initial begin
      string directed[$];
      int random_sent;
      int kind;
      int idx;
      directed = '{"+1", "1-", "1 2", "1+*2", "(*2)", "(2-)", "2(3)", "(2)3", ")",
                   "(", "   ", "9", "^", "a#1", " (-1)+2 ", "2^ 3/ 4"};
      random_sent = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed expressions covering each rule
      foreach (directed[k]) begin
         for (int j = 0; j < directed[k].len(); j++)
            expr_text.push_back(char_type'(directed[k][j]));
         send_expr();
      end
      // codes of no class, extremes of the byte
      expr_text = '{8'h00, CH_PLUS, 8'hFF};
      send_expr();
      // one level past the limit, depth holds at the limit and closes to zero
      repeat (MAX_DEPTH + 1) expr_text.push_back(CH_LPAREN);
      expr_text.push_back(CH_NINE);
      repeat (MAX_DEPTH) expr_text.push_back(CH_RPAREN);
      send_expr();

      // random expressions: mostly well formed, some broken, some noise
      while (random_sent < 250) begin
         calm = (random_sent >= 100 && random_sent < 175);
         kind = $urandom_range(99);
         if (kind < 15) begin
            repeat ($urandom_range(1, 6))
               expr_text.push_back($urandom_range(1) ? char_type'($urandom_range(255))
                                                      : pick_marked());
         end else begin
            maybe_space();
            grow_expr(($urandom_range(9) == 0) ? 4 : $urandom_range(2));
            maybe_space();
            if (kind < 35) begin
               idx = $urandom_range(expr_text.size() - 1);
               case ($urandom_range(2))
                  0: expr_text[idx] = pick_marked();
                  1: expr_text.insert(idx, pick_marked());
                  default: begin
                     if (expr_text.size() > 1) expr_text.delete(idx);
                     else expr_text[idx] = pick_marked();
                  end
               endcase
            end
         end
         random_sent += expr_text.size();
         send_expr();
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && verdicts_owed == 0)
         $display("infix_expression_syntax_checker_top verification clean");
      else
         $display("infix_expression_syntax_checker_top verification failed");
      $finish;
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("infix_expression_syntax_checker_top verification failed");
      $finish;
   end

endmodule

[infix_expression_syntax_checker_top.f]
+incdir+hdl
hdl/iesc_pkg.sv
hdl/infix_expression_syntax_checker_top.sv
bench/syntax_verdict_checker.sv
bench/tb.sv
